// ===== src/gcbt_pkg.sv =====
package gcbt_pkg;

  localparam int unsigned MaxDimsDef   = 4;
  localparam int unsigned CellSlotsDef = 16;
  localparam int unsigned IdCountDef   = 32;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IntvW  = 15;
  localparam int unsigned DimsW  = 3;
  localparam int unsigned IdW    = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 15;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_HAS    = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_DIMS  = 3'd0,
    CFG_INTV0 = 3'd1,
    CFG_INTV1 = 3'd2,
    CFG_INTV2 = 3'd3,
    CFG_INTV3 = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOOKUP,
    S_EXEC,
    S_LIST
  } state_e;

  // table write control
  typedef struct packed {
    logic en;
    logic set_key;
    logic valid;
  } tbl_wr_t;

  // registered lookup answer
  typedef struct packed {
    logic hit;
    logic any_free;
  } tbl_match_t;

endpackage

// ===== src/gcbt_div_lane.sv =====
module gcbt_div_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [gcbt_pkg::CoordW-1:0] dividend_i,
  input  logic [gcbt_pkg::IntvW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [gcbt_pkg::CoordW-1:0]   quot_o
);
  import gcbt_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [CoordW-1:0] num_q, num_d;
  logic [IntvW-1:0]  div_q, div_d;
  logic              neg_q, neg_d;
  logic [CoordW-1:0] trial;
  logic              fits;

  // restoring division on magnitudes, one quotient bit a cycle
  assign trial = {rem_q[CoordW-2:0], num_q[CoordW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd15;
      rem_d  = '0;
      num_d  = dividend_i[CoordW-1] ? (~dividend_i + 16'd1) : dividend_i;
      div_d  = (divisor_i == '0) ? 15'd1 : divisor_i;
      neg_d  = dividend_i[CoordW-1];
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, div_q}) : trial;
      num_d = {num_q[CoordW-2:0], fits};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~num_q + 16'd1) : num_q;

endmodule

// ===== src/gcbt_cell_table.sv =====
module gcbt_cell_table #(
  parameter int unsigned MAX_DIMS   = gcbt_pkg::MaxDimsDef,
  parameter int unsigned CELL_SLOTS = gcbt_pkg::CellSlotsDef,
  parameter int unsigned ID_COUNT   = gcbt_pkg::IdCountDef,
  localparam int unsigned KeyW  = gcbt_pkg::CoordW * MAX_DIMS,
  localparam int unsigned SlotW = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [KeyW-1:0]        key_i,
  input  logic                   capture_i,
  output gcbt_pkg::tbl_match_t   match_o,
  output logic [SlotW-1:0]       hit_slot_o,
  output logic [SlotW-1:0]       free_slot_o,
  output logic [ID_COUNT-1:0]    members_o,
  input  gcbt_pkg::tbl_wr_t      wr_i,
  input  logic [SlotW-1:0]       wr_slot_i,
  input  logic [ID_COUNT-1:0]    wr_members_i
);
  import gcbt_pkg::*;

  logic [CELL_SLOTS-1:0] valid_q;
  logic [KeyW-1:0]       key_q     [CELL_SLOTS];
  logic [ID_COUNT-1:0]   members_q [CELL_SLOTS];

  logic                  hit, any_free;
  logic [SlotW-1:0]      hit_slot, free_slot;
  tbl_match_t            match_q;
  logic [SlotW-1:0]      hit_slot_q, free_slot_q;
  logic [ID_COUNT-1:0]   members_r_q;

  // every slot compares in parallel, lowest index wins
  always_comb begin
    hit       = 1'b0;
    any_free  = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int s = CELL_SLOTS - 1; s >= 0; s--) begin
      if (valid_q[s] && key_q[s] == key_i) begin
        hit      = 1'b1;
        hit_slot = SlotW'(s);
      end
      if (!valid_q[s]) begin
        any_free  = 1'b1;
        free_slot = SlotW'(s);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_slot_i] <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      members_q[wr_slot_i] <= wr_members_i;
      if (wr_i.set_key) begin
        key_q[wr_slot_i] <= key_i;
      end
    end
    if (capture_i) begin
      match_q     <= '{hit: hit, any_free: any_free};
      hit_slot_q  <= hit_slot;
      free_slot_q <= free_slot;
      members_r_q <= members_q[hit_slot];
    end
  end

  assign match_o     = match_q;
  assign hit_slot_o  = hit_slot_q;
  assign free_slot_o = free_slot_q;
  assign members_o   = members_r_q;

endmodule

// ===== src/grid_cell_bucket_table.sv =====
// channel | direction | handshake           | payload
// in      | into      | in_valid_i/in_stall_o   | opcode, coord_0..3, item_id
// out     | out of    | out_valid_o/out_stall_i | status, found, member_id, last
// cfg     | into      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// add and remove pass through the accepting cycle, the per-dimension serial
// dividers (quotient bits, then the done beat), a table lookup state and an
// execute state; has-cell and list skip the dividers; list walks one member bit
// a cycle while the output is free (up to ID_COUNT)
// one item at a time; the output register lets the next beat in while a
// result still waits; reset empties the table at once through per-slot valid bits
module grid_cell_bucket_table #(
  parameter int unsigned MAX_DIMS   = gcbt_pkg::MaxDimsDef,
  parameter int unsigned CELL_SLOTS = gcbt_pkg::CellSlotsDef,
  parameter int unsigned ID_COUNT   = gcbt_pkg::IdCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [gcbt_pkg::CoordW-1:0] coord_0_i,
  input  logic signed [gcbt_pkg::CoordW-1:0] coord_1_i,
  input  logic signed [gcbt_pkg::CoordW-1:0] coord_2_i,
  input  logic signed [gcbt_pkg::CoordW-1:0] coord_3_i,
  input  logic [gcbt_pkg::IdW-1:0]      item_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic                          found_o,
  output logic [gcbt_pkg::IdW-1:0]      member_id_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gcbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gcbt_pkg::CfgW-1:0]     cfg_data_i
);
  import gcbt_pkg::*;

  localparam int unsigned KeyW  = CoordW * MAX_DIMS;
  localparam int unsigned SlotW = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
  localparam int unsigned IdxW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  // configuration registers
  logic [DimsW-1:0] dims_q;
  logic [IntvW-1:0] intv_q [4];
  logic [DimsW-1:0] dims_eff;

  // latched item
  state_e             state_q, state_d;
  op_e                op_q;
  logic [CoordW-1:0]  coord_in [4];
  logic [IdW-1:0]     id_q;
  logic [KeyW-1:0]    key_q, key_d;
  logic               in_acc;

  // lanes
  logic [MAX_DIMS-1:0]   lane_done;
  logic [CoordW-1:0]     lane_quot [MAX_DIMS];
  logic                  lane_start;

  // table
  tbl_match_t           match;
  logic [SlotW-1:0]     hit_slot, free_slot, wr_slot;
  logic [ID_COUNT-1:0]  members, wr_members;
  tbl_wr_t              wr;
  logic                 capture;

  // list walk
  logic [ID_COUNT-1:0]  mask_q, mask_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [ID_COUNT-1:0]  id_bit, mask_rest;
  logic                 id_ok;
  logic [IdxW+IdW-1:0]  idx_ext;

  // output register
  logic           out_valid_q;
  status_e        out_status_q;
  logic           out_found_q, out_last_q;
  logic [IdW-1:0] out_member_q;
  logic           out_free, emit;
  status_e        e_status;
  logic           e_found, e_last;
  logic [IdW-1:0] e_member;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DimsW'(2);
      for (int i = 0; i < 4; i++) intv_q[i] <= IntvW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIMS:  dims_q    <= cfg_data_i[DimsW-1:0];
        CFG_INTV0: intv_q[0] <= cfg_data_i;
        CFG_INTV1: intv_q[1] <= cfg_data_i;
        CFG_INTV2: intv_q[2] <= cfg_data_i;
        CFG_INTV3: intv_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero dims acts as one, beyond the lane count clamps
  always_comb begin
    dims_eff = dims_q;
    if (dims_q == '0) dims_eff = DimsW'(1);
    if (dims_q > DimsW'(MAX_DIMS)) dims_eff = DimsW'(MAX_DIMS);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lane_start = in_acc && (opcode_i == OP_ADD || opcode_i == OP_REMOVE);

  // raw cell indices straight from the input beat
  assign coord_in[0] = coord_0_i;
  assign coord_in[1] = coord_1_i;
  assign coord_in[2] = coord_2_i;
  assign coord_in[3] = coord_3_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= op_e'(opcode_i);
      id_q       <= item_id_i;
    end
    key_q <= key_d;
  end

  // one divider lane per dimension
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    logic signed [CoordW-1:0] lane_in;
    always_comb begin
      case (d)
        0:       lane_in = coord_0_i;
        1:       lane_in = coord_1_i;
        2:       lane_in = coord_2_i;
        default: lane_in = coord_3_i;
      endcase
    end
    gcbt_div_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (lane_start),
      .dividend_i (lane_in),
      .divisor_i  (intv_q[d]),
      .done_o     (lane_done[d]),
      .quot_o     (lane_quot[d])
    );
  end

  // merge: build the key from quotients or raw cell indices
  always_comb begin
    key_d = key_q;
    if (state_q == S_DIV && lane_done[0]) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        key_d[d*CoordW +: CoordW] = (DimsW'(d) < dims_eff) ? lane_quot[d] : '0;
      end
    end else if (state_q == S_IDLE) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        key_d[d*CoordW +: CoordW] = (DimsW'(d) < dims_eff) ? coord_in[d] : '0;
      end
    end
  end

  assign capture = (state_q == S_LOOKUP);

  gcbt_cell_table #(
    .MAX_DIMS   (MAX_DIMS),
    .CELL_SLOTS (CELL_SLOTS),
    .ID_COUNT   (ID_COUNT)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_q),
    .capture_i    (capture),
    .match_o      (match),
    .hit_slot_o   (hit_slot),
    .free_slot_o  (free_slot),
    .members_o    (members),
    .wr_i         (wr),
    .wr_slot_i    (wr_slot),
    .wr_members_i (wr_members)
  );

  always_comb begin
    for (int j = 0; j < ID_COUNT; j++) begin
      id_bit[j] = ({2'b00, id_q} == 7'(j));
    end
  end
  assign id_ok     = ({2'b00, id_q} < 7'(ID_COUNT));
  assign mask_rest = mask_q & ~(ID_COUNT'(1) << idx_q);
  assign idx_ext   = {{IdW{1'b0}}, idx_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_found    = 1'b0;
    e_member   = '0;
    e_last     = 1'b1;
    wr         = '{en: 1'b0, set_key: 1'b0, valid: 1'b0};
    wr_slot    = match.hit ? hit_slot : free_slot;
    wr_members = members;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = lane_start ? S_DIV : S_LOOKUP;
        end
      end
      S_DIV: begin
        if (lane_done[0]) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            OP_ADD: begin
              if (!id_ok) begin
                e_status = ST_NOT_FOUND;
              end else if (match.hit) begin
                wr         = '{en: 1'b1, set_key: 1'b0, valid: 1'b1};
                wr_members = members | id_bit;
              end else if (match.any_free) begin
                wr         = '{en: 1'b1, set_key: 1'b1, valid: 1'b1};
                wr_members = id_bit;
              end else begin
                e_status = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (!id_ok || !match.hit || (members & id_bit) == '0) begin
                e_status = ST_NOT_FOUND;
              end else begin
                wr_members = members & ~id_bit;
                wr = '{en: 1'b1, set_key: 1'b0, valid: (wr_members != '0)};
              end
            end
            OP_HAS: begin
              e_found = match.hit;
            end
            default: begin
              if (!match.hit || members == '0) begin
                e_status = ST_NOT_FOUND;
              end else begin
                emit    = 1'b0;
                mask_d  = members;
                idx_d   = '0;
                state_d = S_LIST;
              end
            end
          endcase
        end
      end
      S_LIST: begin
        // one member bit a cycle, held while the output is full
        if (mask_q[idx_q]) begin
          if (out_free) begin
            emit     = 1'b1;
            e_member = idx_ext[IdW-1:0];
            e_last   = (mask_rest == '0);
            mask_d   = mask_rest;
            idx_d    = idx_q + IdxW'(1);
            if (mask_rest == '0) state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    idx_q  <= idx_d;
    if (emit) begin
      out_status_q <= e_status;
      out_found_q  <= e_found;
      out_member_q <= e_member;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign member_id_o = out_member_q;
  assign last_o      = out_last_q;

  // the list walk never runs on an empty bitmap
  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> mask_q != '0)
    else $error("list walk with empty bitmap");

  // a found answer is always an ok result
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("found with bad status");

  // all lanes finish together
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (&lane_done) || !(|lane_done))
    else $error("divider lanes out of step");

  // a result is only loaded while the output can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result overwritten");

endmodule

// ===== tb/tb_grid_cell_bucket_table.sv =====
module tb_grid_cell_bucket_table;
  import gcbt_pkg::*;

  // one request beat into the block
  typedef struct packed {
    op_e              op;
    logic [3:0][15:0] c;
    logic [4:0]       id;
  } grid_req_t;

  // one result beat out of the block
  typedef struct packed {
    status_e    st;
    logic       found;
    logic [4:0] member;
    logic       last;
  } grid_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side, driven on the falling edge
  grid_req_t offer = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_stall = 1'b0;

  // configuration channel, driven from the sequence block
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  cfg_idx_e       cfg_index = CFG_DIMS;
  logic [CfgW-1:0] cfg_data = '0;

  logic       out_valid;
  logic [1:0] status;
  logic       found;
  logic [4:0] member_id;
  logic       last;

  always #5 clk_i = ~clk_i;

  grid_cell_bucket_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (offer.op),
    .coord_0_i   (offer.c[0]),
    .coord_1_i   (offer.c[1]),
    .coord_2_i   (offer.c[2]),
    .coord_3_i   (offer.c[3]),
    .item_id_i   (offer.id),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .found_o     (found),
    .member_id_o (member_id),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // shadow of the block: registers and cell table
  logic [2:0]  dims_reg = 3'd2;
  logic [14:0] grid_step [4] = '{15'd1, 15'd1, 15'd1, 15'd1};
  logic        slot_used [16];
  logic [63:0] slot_key [16];
  logic [31:0] slot_ids [16];

  grid_req_t  pending_reqs [$];
  grid_resp_t awaited_beats [$];
  logic [3:0][15:0] feature_pool [$];

  int  n_sent = 0;
  int  n_taken = 0;
  int  cycles = 0;
  int  errors = 0;
  int  beats_seen = 0;
  int  list_beats = 0;
  int  full_hits = 0;
  bit  quiet = 1'b0;

  // cell key from coordinates, divided for add and remove
  function automatic logic [63:0] cell_key_of(grid_req_t r, bit divide);
    logic [63:0] k;
    int nd;
    int v;
    int iv;
    k = '0;
    nd = (dims_reg == 0) ? 1 : (dims_reg > 4) ? 4 : dims_reg;
    for (int d = 0; d < nd; d++) begin
      v = $signed(r.c[d]);
      if (divide) begin
        iv = (grid_step[d] == 0) ? 1 : grid_step[d];
        v = v / iv;
      end
      k[16*d +: 16] = v[15:0];
    end
    return k;
  endfunction

  function automatic int slot_of(logic [63:0] k);
    for (int s = 0; s < 16; s++)
      if (slot_used[s] && slot_key[s] == k) return s;
    return -1;
  endfunction

  function automatic void await_beat(status_e st, logic f, logic [4:0] m, logic l);
    grid_resp_t b;
    b.st = st;
    b.found = f;
    b.member = m;
    b.last = l;
    awaited_beats = {awaited_beats, b};
  endfunction

  // applies one request to the shadow table and queues its result beats
  function automatic void bucket_request(grid_req_t r);
    logic [63:0] k;
    int s;
    int n;
    k = cell_key_of(r, r.op inside {OP_ADD, OP_REMOVE});
    s = slot_of(k);
    case (r.op)
      OP_ADD: begin
        if (s < 0) begin
          for (int t = 0; t < 16; t++)
            if (!slot_used[t] && s < 0) s = t;
          if (s >= 0) begin
            slot_used[s] = 1'b1;
            slot_key[s] = k;
            slot_ids[s] = '0;
          end
        end
        if (s < 0) begin
          full_hits++;
          await_beat(ST_FULL, 1'b0, 5'd0, 1'b1);
        end else begin
          slot_ids[s][r.id] = 1'b1;
          await_beat(ST_OK, 1'b0, 5'd0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (s < 0 || !slot_ids[s][r.id]) begin
          await_beat(ST_NOT_FOUND, 1'b0, 5'd0, 1'b1);
        end else begin
          slot_ids[s][r.id] = 1'b0;
          if (slot_ids[s] == 0) slot_used[s] = 1'b0;
          await_beat(ST_OK, 1'b0, 5'd0, 1'b1);
        end
      end
      OP_HAS: await_beat(ST_OK, s >= 0, 5'd0, 1'b1);
      default: begin
        if (s < 0 || slot_ids[s] == 0) begin
          await_beat(ST_NOT_FOUND, 1'b0, 5'd0, 1'b1);
        end else begin
          n = $countones(slot_ids[s]);
          for (int i = 0; i < 32; i++)
            if (slot_ids[s][i]) begin
              n--;
              await_beat(ST_OK, 1'b0, i[4:0], n == 0);
            end
        end
      end
    endcase
  endfunction

  // sender and receiver pacing, both on the falling edge
  always @(negedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    if (rst_ni && n_sent == n_taken) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
        offer <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        n_sent <= n_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept, predict and check on the rising edge
  always @(posedge clk_i) begin
    grid_resp_t want;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout at cycle %0d", cycles);
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && in_valid && !in_stall) begin
      bucket_request(offer);
      n_taken <= n_taken + 1;
    end
    if (rst_ni && out_valid && !out_stall) begin
      beats_seen++;
      if (awaited_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat status %0d member %0d", $time, status, member_id);
      end else begin
        want = awaited_beats.pop_front();
        if (want.member != 0 || want.st == ST_OK && !want.last) list_beats++;
        if (status != want.st || found != want.found || member_id != want.member
            || last != want.last) begin
          errors++;
          $display("%0t: expected st %0d found %0d id %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.st, want.found, want.member, want.last,
                   status, found, member_id, last);
        end
      end
    end
  end

  // write one register, keeping the shadow copy in step
  task automatic reg_write(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_DIMS) dims_reg = val[2:0];
    else grid_step[idx - 1] = val;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // waits until every request is sent and every awaited beat is in, plus a short tail
  task automatic drain();
    while (pending_reqs.size() > 0 || n_sent != n_taken || awaited_beats.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_req(op_e op, int c0, int c1, int id);
    grid_req_t r;
    r.op = op;
    r.c[0] = c0[15:0];
    r.c[1] = c1[15:0];
    r.c[2] = 16'($urandom());
    r.c[3] = 16'($urandom());
    r.id = id[4:0];
    pending_reqs = {pending_reqs, r};
  endtask

  // well-formed requests on a small pool of features, with some pure noise
  task automatic push_random(int count, int pool_size);
    grid_req_t r;
    logic [3:0][15:0] f;
    int iv;
    int q;
    feature_pool.delete();
    for (int i = 0; i < pool_size; i++) feature_pool = {feature_pool, {$urandom(), $urandom()}};
    repeat (count) begin
      r.c = {$urandom(), $urandom()};
      r.id = 5'($urandom());
      r.op = op_e'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 80) begin
        f = feature_pool[$urandom_range(0, pool_size - 1)];
        if ($urandom_range(0, 3) == 0) r.id = 5'($urandom_range(0, 3));
        if (r.op inside {OP_ADD, OP_REMOVE}) begin
          r.c = f;
        end else begin
          for (int d = 0; d < 4; d++) begin
            iv = (grid_step[d] == 0) ? 1 : grid_step[d];
            q = $signed(f[d]) / iv;
            r.c[d] = q[15:0];
          end
        end
      end
      pending_reqs = {pending_reqs, r};
    end
  endtask

  initial begin
    for (int s = 0; s < 16; s++) begin
      slot_used[s] = 1'b0;
      slot_ids[s] = '0;
      slot_key[s] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, two dimensions, unit intervals
    push_req(OP_ADD, 0, 0, 0);
    push_req(OP_ADD, 0, 0, 31);
    push_req(OP_ADD, -32768, 32767, 5);
    push_req(OP_HAS, 0, 0, 0);
    push_req(OP_HAS, 1, 1, 0);
    push_req(OP_LIST, 0, 0, 0);
    push_req(OP_LIST, -32768, 32767, 0);
    push_req(OP_LIST, 3, 3, 0);
    push_req(OP_REMOVE, 0, 0, 7);        // id not in the cell
    push_req(OP_REMOVE, 9, 9, 0);        // cell absent, must not leave an empty cell
    push_req(OP_HAS, 9, 9, 0);
    push_req(OP_REMOVE, 0, 0, 0);
    push_req(OP_LIST, 0, 0, 0);
    push_req(OP_REMOVE, 0, 0, 31);       // last member leaves, cell freed
    push_req(OP_HAS, 0, 0, 0);
    push_req(OP_LIST, 0, 0, 0);
    push_req(OP_ADD, 32767, -32768, 16);
    push_req(OP_LIST, 32767, -32768, 0);
    push_req(OP_REMOVE, -32768, 32767, 5);
    push_req(OP_HAS, -32768, 32767, 0);
    drain();

    // four dimensions, mixed intervals
    reg_write(CFG_DIMS, 15'd4);
    reg_write(CFG_INTV0, 15'd3);
    reg_write(CFG_INTV1, 15'd7);
    reg_write(CFG_INTV2, 15'd100);
    reg_write(CFG_INTV3, 15'd32767);
    push_random(30, 5);
    drain();
    push_random(30, 5);
    drain();

    // dims of zero behaves as one, zero interval as one; fill the table, no idling
    quiet = 1'b1;
    reg_write(CFG_DIMS, 15'd0);
    reg_write(CFG_INTV0, 15'd0);
    for (int i = 0; i < 20; i++) push_req(OP_ADD, i * 37 - 300, 0, i);
    for (int i = 0; i < 6; i++) push_req(OP_LIST, i * 37 - 300, 0, 0);
    for (int i = 0; i < 20; i++) push_req(OP_REMOVE, i * 37 - 300, 0, i);
    drain();
    quiet = 1'b0;
    push_random(25, 4);
    drain();

    // dims above the maximum, extreme intervals
    reg_write(CFG_DIMS, 15'd7);
    reg_write(CFG_INTV0, 15'd32767);
    reg_write(CFG_INTV1, 15'd1);
    reg_write(CFG_INTV2, 15'd0);
    reg_write(CFG_INTV3, 15'd5);
    push_random(60, 6);
    drain();

    $display("%0d requests, %0d result beats (%0d list members, %0d table-full answers)",
             n_taken, beats_seen, list_beats, full_hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
